/* hdl/lemc_pkg.sv */
// lemc_pkg: shared types and constants for the led effect mode controller
// no dependencies; used by every file under hdl
`timescale 1ns / 1ps

package lemc_pkg;

  localparam int unsigned UPD_W    = 11;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned HUE_W    = 11;
  localparam int unsigned STYLE_W  = 3;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 16;

  localparam logic [HUE_W-1:0]   HUE_LAST    = 11'd1529;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
  localparam logic [CNT_W-1:0]   FLASH_MULT  = 16'd25;
  localparam logic [UPD_W-1:0]   UPD_RESET   = 11'd10;
  localparam logic [CNT_W-1:0]   DEB_RESET   = 16'd50;
  localparam logic [STYLE_W-1:0] STYLE_LAST  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b1;

  typedef enum logic [1:0] {
    OVR_NORMAL = 2'd0,
    OVR_OEM    = 2'd1,
    OVR_OFF    = 2'd2,
    OVR_SPARE  = 2'd3
  } ovr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_COLOUR = 3'd1,
    KIND_GAUGE  = 3'd2,
    KIND_OEM    = 3'd3,
    KIND_OFF    = 3'd4
  } kind_t;

  typedef enum logic [STYLE_W-1:0] {
    STY_RAINBOW_GAUGE = 3'd0,
    STY_RAINBOW       = 3'd1,
    STY_GREEN         = 3'd2,
    STY_FLASH_GREEN   = 3'd3,
    STY_FLASH_BLUE    = 3'd4,
    STY_FLASH_PINK    = 3'd5,
    STY_RED           = 3'd6,
    STY_BAD           = 3'd7
  } style_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    kind_t      kind;
    style_t     style;
  } frame_t;

endpackage

/* hdl/lemc_wheel.sv */
// lemc_wheel: maps a hue position 0..1529 onto an rgb colour
// depends on lemc_pkg
`timescale 1ns / 1ps

module lemc_wheel (
  input  logic [lemc_pkg::HUE_W-1:0] hue,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue
);

  logic [lemc_pkg::HUE_W-1:0] d510;
  logic [lemc_pkg::HUE_W-1:0] d1020;
  logic [lemc_pkg::HUE_W-1:0] d1530;
  logic [lemc_pkg::HUE_W-1:0] s510;
  logic [lemc_pkg::HUE_W-1:0] s1020;

  assign d510  = 11'd510 - hue;
  assign d1020 = 11'd1020 - hue;
  assign d1530 = 11'd1530 - hue;
  assign s510  = hue - 11'd510;
  assign s1020 = hue - 11'd1020;

  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    if (hue <= 11'd255) begin
      red  = 8'd255;
      blue = hue[7:0];
    end else if (hue <= 11'd510) begin
      red  = d510[7:0];
      blue = 8'd255;
    end else if (hue <= 11'd765) begin
      green = s510[7:0];
      blue  = 8'd255;
    end else if (hue <= 11'd1020) begin
      green = 8'd255;
      blue  = d1020[7:0];
    end else if (hue <= 11'd1275) begin
      red   = s1020[7:0];
      green = 8'd255;
    end else if (hue <= 11'd1530) begin
      red   = 8'd255;
      green = d1530[7:0];
    end
  end

endmodule

/* hdl/lemc_core.sv */
// lemc_core: effect state (hue, style, flash phase, elapsed counters) and frame logic
// depends on lemc_pkg and lemc_wheel
`timescale 1ns / 1ps

module lemc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         up_pressed,
  input  logic                         down_pressed,
  input  lemc_pkg::ovr_t               override_mode,
  input  logic [lemc_pkg::UPD_W-1:0]   update_interval,
  input  logic [lemc_pkg::CNT_W-1:0]   flash_interval,
  input  logic [lemc_pkg::CNT_W-1:0]   debounce_interval,
  output lemc_pkg::frame_t             frame
);

  logic [lemc_pkg::HUE_W-1:0] hue_r, hue_nxt, hue_step;
  lemc_pkg::style_t           style_r, style_nxt, style_btn;
  logic                       bright_r, bright_nxt;
  logic [lemc_pkg::CNT_W-1:0] refresh_r, refresh_nxt, refresh_inc;
  logic [lemc_pkg::CNT_W-1:0] press_r, press_nxt, press_inc;
  logic                       debounced;
  logic [7:0]                 wh_red, wh_green, wh_blue;

  assign refresh_inc = (refresh_r == lemc_pkg::CNT_MAX) ? refresh_r : refresh_r + 16'd1;
  assign press_inc   = (press_r == lemc_pkg::CNT_MAX) ? press_r : press_r + 16'd1;
  assign debounced   = press_inc > debounce_interval;
  assign hue_step    = (hue_r >= lemc_pkg::HUE_LAST) ? '0 : hue_r + 11'd1;

  lemc_wheel u_wheel (
    .hue   (hue_step),
    .red   (wh_red),
    .green (wh_green),
    .blue  (wh_blue)
  );

  // down wins; up is ignored when both are pressed
  always_comb begin
    style_btn = style_r;
    if (down_pressed && debounced) begin
      style_btn = (style_r == lemc_pkg::STY_RAINBOW_GAUGE) ? lemc_pkg::STY_RED
                : lemc_pkg::style_t'(style_r - 3'd1);
    end else if (up_pressed && debounced) begin
      style_btn = (style_r >= lemc_pkg::STYLE_LAST) ? lemc_pkg::STY_RAINBOW_GAUGE
                : lemc_pkg::style_t'(style_r + 3'd1);
    end
  end

  always_comb begin
    hue_nxt     = hue_r;
    style_nxt   = style_btn;
    bright_nxt  = bright_r;
    refresh_nxt = refresh_inc;
    press_nxt   = (up_pressed || down_pressed) ? '0 : press_inc;
    frame       = '0;
    frame.kind  = lemc_pkg::KIND_NONE;
    case (override_mode)
      lemc_pkg::OVR_OEM: frame.kind = lemc_pkg::KIND_OEM;
      lemc_pkg::OVR_OFF: frame.kind = lemc_pkg::KIND_OFF;
      default: begin
        case (style_btn)
          lemc_pkg::STY_RAINBOW_GAUGE, lemc_pkg::STY_RAINBOW: begin
            if (refresh_inc > {5'd0, update_interval}) begin
              hue_nxt     = hue_step;
              frame.red   = wh_red;
              frame.green = wh_green;
              frame.blue  = wh_blue;
              frame.kind  = (style_btn == lemc_pkg::STY_RAINBOW_GAUGE) ?
                            lemc_pkg::KIND_GAUGE : lemc_pkg::KIND_COLOUR;
              refresh_nxt = '0;
            end
          end
          lemc_pkg::STY_GREEN: begin
            frame.green = 8'd255;
            frame.kind  = lemc_pkg::KIND_COLOUR;
          end
          lemc_pkg::STY_FLASH_GREEN, lemc_pkg::STY_FLASH_BLUE,
          lemc_pkg::STY_FLASH_PINK: begin
            if (refresh_inc > flash_interval) begin
              if (style_btn == lemc_pkg::STY_FLASH_GREEN) begin
                frame.green = bright_r ? 8'd255 : 8'd100;
              end else if (style_btn == lemc_pkg::STY_FLASH_BLUE) begin
                frame.blue = bright_r ? 8'd255 : 8'd100;
              end else begin
                frame.red  = bright_r ? 8'd255 : 8'd100;
                frame.blue = bright_r ? 8'd175 : 8'd68;
              end
              bright_nxt  = ~bright_r;
              frame.kind  = lemc_pkg::KIND_COLOUR;
              refresh_nxt = '0;
            end
          end
          lemc_pkg::STY_RED: begin
            frame.red  = 8'd255;
            frame.kind = lemc_pkg::KIND_COLOUR;
          end
          default: style_nxt = lemc_pkg::STY_RAINBOW_GAUGE;
        endcase
      end
    endcase
    frame.style = style_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r     <= '0;
      style_r   <= lemc_pkg::STY_RAINBOW_GAUGE;
      bright_r  <= 1'b1;
      refresh_r <= '0;
      press_r   <= '0;
    end else if (accept) begin
      hue_r     <= hue_nxt;
      style_r   <= style_nxt;
      bright_r  <= bright_nxt;
      refresh_r <= refresh_nxt;
      press_r   <= press_nxt;
    end
  end

endmodule

/* hdl/led_effect_mode_controller.sv */
// led_effect_mode_controller: top level with config registers and output register
// depends on lemc_pkg and lemc_core
`timescale 1ns / 1ps
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tdata: up, down   tuser: override_mode
//  out_     out  out_tvalid / out_tready tdata: r, g, b, style  tuser: frame_kind
//  cfg_     in   cfg_we                  cfg_index, cfg_wdata
//
//  one tick word per cycle unless out_ stalls; frame on out_ in the cycle after acceptance
//  the single output register is reloaded in the cycle it is taken, so in_tready
//  stays high under a free-flowing sink and drops only while a frame is held
//  synchronous active-low reset gives style 0, hue 0, bright flash phase, counters 0
//  flash threshold (25 times update_interval) is worked out when the register is written

module led_effect_mode_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // up_pressed, down_pressed
  input  logic [1:0]                      in_tuser,   // override_mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // red, green, blue, style_now
  output logic [2:0]                      out_tuser,  // frame_kind
  input  logic                            cfg_we,
  input  logic [lemc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lemc_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [lemc_pkg::UPD_W-1:0] upd_r;
  logic [lemc_pkg::CNT_W-1:0] flash_r;
  logic [lemc_pkg::CNT_W-1:0] deb_r;
  logic                       out_valid_r;
  lemc_pkg::frame_t           frame_nxt, frame_r;
  logic                       accept;
  logic [31:0]                flash_prod;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign flash_prod = {21'd0, cfg_wdata[lemc_pkg::UPD_W-1:0]} * {16'd0, lemc_pkg::FLASH_MULT};

  lemc_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .up_pressed        (in_tdata[0]),
    .down_pressed      (in_tdata[1]),
    .override_mode     (lemc_pkg::ovr_t'(in_tuser)),
    .update_interval   (upd_r),
    .flash_interval    (flash_r),
    .debounce_interval (deb_r),
    .frame             (frame_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r       <= lemc_pkg::UPD_RESET;
      flash_r     <= 16'd250;
      deb_r       <= lemc_pkg::DEB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lemc_pkg::CFG_UPDATE: begin
            upd_r   <= cfg_wdata[lemc_pkg::UPD_W-1:0];
            flash_r <= flash_prod[lemc_pkg::CNT_W-1:0];
          end
          lemc_pkg::CFG_DEBOUNCE: deb_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_r <= frame_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, frame_r.style, frame_r.blue, frame_r.green, frame_r.red};
  assign out_tuser  = frame_r.kind;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for led_effect_mode_controller, one tick word per item
// a directed table then random phases under several register settings; depends on lemc_pkg
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    bit                up;
    bit                dn;
    lemc_pkg::ovr_t    ovr;
    bit                typed;
    lemc_pkg::frame_t  frame;
  } tick_row_t;

  localparam int DIR_ROWS = 20;

  // written for update_interval 0 and debounce_interval 0 straight after reset
  localparam tick_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, 1'b0, lemc_pkg::OVR_NORMAL, 1'b1,
      '{8'd255, 8'd0, 8'd1, lemc_pkg::KIND_GAUGE, lemc_pkg::STY_RAINBOW_GAUGE}},
    '{1'b0, 1'b0, lemc_pkg::OVR_OEM,    1'b1,
      '{8'd0, 8'd0, 8'd0, lemc_pkg::KIND_OEM, lemc_pkg::STY_RAINBOW_GAUGE}},
    '{1'b0, 1'b0, lemc_pkg::OVR_OFF,    1'b1,
      '{8'd0, 8'd0, 8'd0, lemc_pkg::KIND_OFF, lemc_pkg::STY_RAINBOW_GAUGE}},
    '{1'b0, 1'b0, lemc_pkg::OVR_SPARE,  1'b0, '0},
    '{1'b0, 1'b1, lemc_pkg::OVR_NORMAL, 1'b1,
      '{8'd255, 8'd0, 8'd0, lemc_pkg::KIND_COLOUR, lemc_pkg::STY_RED}},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b1,
      '{8'd0, 8'd255, 8'd0, lemc_pkg::KIND_COLOUR, lemc_pkg::STY_GREEN}},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b0, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b0, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b0, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b1,
      '{8'd255, 8'd0, 8'd0, lemc_pkg::KIND_COLOUR, lemc_pkg::STY_RED}},
    '{1'b1, 1'b0, lemc_pkg::OVR_NORMAL, 1'b0, '0},
    '{1'b1, 1'b1, lemc_pkg::OVR_NORMAL, 1'b1,
      '{8'd255, 8'd0, 8'd0, lemc_pkg::KIND_COLOUR, lemc_pkg::STY_RED}},
    '{1'b1, 1'b1, lemc_pkg::OVR_OEM,    1'b1,
      '{8'd0, 8'd0, 8'd0, lemc_pkg::KIND_OEM, lemc_pkg::STY_FLASH_PINK}},
    '{1'b0, 1'b1, lemc_pkg::OVR_OFF,    1'b1,
      '{8'd0, 8'd0, 8'd0, lemc_pkg::KIND_OFF, lemc_pkg::STY_FLASH_BLUE}},
    '{1'b0, 1'b1, lemc_pkg::OVR_SPARE,  1'b0, '0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // up_pressed, down_pressed
  logic [1:0]                     in_tuser;   // override_mode
  logic                           out_tvalid;
  logic                           out_tready;
  logic [31:0]                    out_tdata;  // red, green, blue, style_now
  logic [2:0]                     out_tuser;  // frame_kind
  logic                           cfg_we;
  logic [lemc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lemc_pkg::CFG_W-1:0]     cfg_wdata;

  // predictor copy of registers and state
  logic [lemc_pkg::UPD_W-1:0] upd_ivl;
  logic [lemc_pkg::CNT_W-1:0] deb_ivl;
  logic [lemc_pkg::HUE_W-1:0] hue;
  lemc_pkg::style_t           style;
  bit                         flash_bright;
  logic [lemc_pkg::CNT_W-1:0] since_refresh;
  logic [lemc_pkg::CNT_W-1:0] since_press;

  lemc_pkg::frame_t frames_due[$];
  int               bad_frames = 0;
  int               in_quiet = 0;
  int               out_quiet = 0;

  led_effect_mode_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [23:0] wheel_rgb(int h);
    if (h <= 255) return {8'd255, 8'd0, 8'(h)};
    if (h <= 510) return {8'(510 - h), 8'd0, 8'd255};
    if (h <= 765) return {8'd0, 8'(h - 510), 8'd255};
    if (h <= 1020) return {8'd0, 8'd255, 8'(1020 - h)};
    if (h <= 1275) return {8'(h - 1020), 8'd255, 8'd0};
    if (h <= 1530) return {8'd255, 8'(1530 - h), 8'd0};
    return 24'd0;
  endfunction

  function automatic lemc_pkg::frame_t predict_frame(bit up, bit dn, lemc_pkg::ovr_t ovr);
    lemc_pkg::frame_t f;
    bit               bright;
    f = '0;
    if (since_refresh != lemc_pkg::CNT_MAX) since_refresh = since_refresh + 16'd1;
    if (since_press != lemc_pkg::CNT_MAX) since_press = since_press + 16'd1;
    if (dn) begin
      if (since_press > deb_ivl)
        style = (style == lemc_pkg::STY_RAINBOW_GAUGE) ?
                lemc_pkg::style_t'(lemc_pkg::STYLE_LAST) : lemc_pkg::style_t'(style - 3'd1);
      since_press = '0;
    end
    if (up) begin
      if (since_press > deb_ivl)
        style = (style >= lemc_pkg::STYLE_LAST) ?
                lemc_pkg::STY_RAINBOW_GAUGE : lemc_pkg::style_t'(style + 3'd1);
      since_press = '0;
    end
    if (ovr == lemc_pkg::OVR_OEM) begin
      f.kind = lemc_pkg::KIND_OEM;
    end else if (ovr == lemc_pkg::OVR_OFF) begin
      f.kind = lemc_pkg::KIND_OFF;
    end else begin
      case (style)
        lemc_pkg::STY_RAINBOW_GAUGE, lemc_pkg::STY_RAINBOW: begin
          if (since_refresh > {5'd0, upd_ivl}) begin
            hue = (hue >= lemc_pkg::HUE_LAST) ? '0 : hue + 11'd1;
            {f.red, f.green, f.blue} = wheel_rgb(int'(hue));
            f.kind = (style == lemc_pkg::STY_RAINBOW_GAUGE) ?
                     lemc_pkg::KIND_GAUGE : lemc_pkg::KIND_COLOUR;
            since_refresh = '0;
          end
        end
        lemc_pkg::STY_GREEN: begin
          f.green = 8'd255;
          f.kind = lemc_pkg::KIND_COLOUR;
        end
        lemc_pkg::STY_FLASH_GREEN, lemc_pkg::STY_FLASH_BLUE, lemc_pkg::STY_FLASH_PINK: begin
          if (int'(since_refresh) > int'(upd_ivl) * int'(lemc_pkg::FLASH_MULT)) begin
            bright = flash_bright;
            case (style)
              lemc_pkg::STY_FLASH_GREEN: f.green = bright ? 8'd255 : 8'd100;
              lemc_pkg::STY_FLASH_BLUE:  f.blue = bright ? 8'd255 : 8'd100;
              default: begin
                f.red = bright ? 8'd255 : 8'd100;
                f.blue = bright ? 8'd175 : 8'd68;
              end
            endcase
            flash_bright = !bright;
            f.kind = lemc_pkg::KIND_COLOUR;
            since_refresh = '0;
          end
        end
        lemc_pkg::STY_RED: begin
          f.red = 8'd255;
          f.kind = lemc_pkg::KIND_COLOUR;
        end
        default: style = lemc_pkg::STY_RAINBOW_GAUGE;
      endcase
    end
    f.style = style;
    return f;
  endfunction

  // mostly short gaps, a few long ones, now and then a quiet stretch
  function automatic int pick_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_bad(string msg);
    if (bad_frames < 10) $display("%0t: %s", $time, msg);
    bad_frames++;
  endfunction

  task automatic write_reg(logic [lemc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= lemc_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lemc_pkg::CFG_UPDATE) upd_ivl = lemc_pkg::UPD_W'(val);
    else deb_ivl = lemc_pkg::CNT_W'(val);
  endtask

  task automatic send_tick(bit up, bit dn, lemc_pkg::ovr_t ovr, bit typed = 1'b0,
                           lemc_pkg::frame_t given = '0);
    lemc_pkg::frame_t f;
    int               gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, dn, up};
    in_tuser  <= ovr;
    do @(posedge clk); while (in_tready !== 1'b1);
    f = predict_frame(up, dn, ovr);
    frames_due.push_back(typed ? given : f);
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_random(int n, int press_pct, int ovr_pct);
    lemc_pkg::ovr_t ovr;
    repeat (n) begin
      if (int'($urandom_range(0, 99)) < ovr_pct)
        ovr = $urandom_range(0, 1) ? lemc_pkg::OVR_OEM : lemc_pkg::OVR_OFF;
      else
        ovr = ($urandom_range(0, 9) == 0) ? lemc_pkg::OVR_SPARE : lemc_pkg::OVR_NORMAL;
      send_tick(int'($urandom_range(0, 99)) < press_pct,
                int'($urandom_range(0, 99)) < press_pct, ovr);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      stall = pick_gap(out_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lemc_pkg::frame_t got;
    lemc_pkg::frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red   = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue  = out_tdata[23:16];
      got.kind  = lemc_pkg::kind_t'(out_tuser);
      got.style = lemc_pkg::style_t'(out_tdata[26:24]);
      if (frames_due.size() == 0) begin
        note_bad($sformatf("frame with none due: tdata %h tuser %h", out_tdata, out_tuser));
      end else begin
        want = frames_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.kind !== want.kind || got.style !== want.style)
          note_bad($sformatf("rgb %0d %0d %0d kind %0d style %0d, due %0d %0d %0d %0d %0d",
                             got.red, got.green, got.blue, got.kind, got.style,
                             want.red, want.green, want.blue, want.kind, want.style));
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    upd_ivl       = lemc_pkg::UPD_RESET;
    deb_ivl       = lemc_pkg::DEB_RESET;
    hue           = '0;
    style         = lemc_pkg::STY_RAINBOW_GAUGE;
    flash_bright  = 1'b1;
    since_refresh = '0;
    since_press   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // hue step every tick, every press counts
    write_reg(lemc_pkg::CFG_UPDATE, 0);
    write_reg(lemc_pkg::CFG_DEBOUNCE, 0);
    for (int i = 0; i < DIR_ROWS; i++)
      send_tick(DIRECTED[i].up, DIRECTED[i].dn, DIRECTED[i].ovr,
                DIRECTED[i].typed, DIRECTED[i].frame);
    run_random(100, 20, 10);

    // steer into a rainbow style, then run the hue once round the wheel
    while (style > lemc_pkg::STY_RAINBOW) send_tick(1'b1, 1'b0, lemc_pkg::OVR_NORMAL);
    run_random(1535, 0, 0);

    drain();
    write_reg(lemc_pkg::CFG_UPDATE, lemc_pkg::UPD_RESET);
    write_reg(lemc_pkg::CFG_DEBOUNCE, lemc_pkg::DEB_RESET);
    run_random(100, 3, 10);

    // slow hue, presses never get past the debounce
    drain();
    write_reg(lemc_pkg::CFG_UPDATE, 2000);
    write_reg(lemc_pkg::CFG_DEBOUNCE, lemc_pkg::CNT_MAX);
    run_random(60, 20, 10);

    repeat (2) begin
      drain();
      write_reg(lemc_pkg::CFG_UPDATE, $urandom_range(1, 4));
      write_reg(lemc_pkg::CFG_DEBOUNCE, $urandom_range(0, 8));
      run_random(75, 10, 10);
    end

    drain();
    repeat (20) @(posedge clk);
    if (frames_due.size() != 0)
      note_bad($sformatf("%0d frames never arrived", frames_due.size()));
    if (bad_frames == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
